FILE: rtl/prq_pkg.sv
// Package for the priority ready queue set: request modes, status codes,
// field widths and parameter defaults. No dependencies.
package prq_pkg;

	localparam int SLOT_W = 6;
	localparam int LEVEL_W = 6;
	localparam int COUNT_W = 7;

	localparam int PRIO_LEVELS_DEF = 32;
	localparam int THREAD_SLOTS_DEF = 64;

	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_DEQ = 2'd1;
	localparam logic [1:0] MODE_RMV = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

endpackage

FILE: rtl/priority_ready_queue_set.sv
// A rejected or empty request goes from accept straight to the output state; an
// enqueue passes through ENQ and ENQ2, a dequeue or remove through FETCH and UNLINK.
// No new request is taken until the last result word is loaded, since in_stall is
// high outside idle. Steps wait on synchronous reads of head, tail, link, level memories.
// Reset: asynchronous, active low; clears the non-empty and queued bits, the
// ready count and the handshake state. Memory contents are not cleared.
// Top level of the priority ready queue set; uses prq_pkg.
// Holds per-level head and tail memories and per-slot link and level memories.
module priority_ready_queue_set
	import prq_pkg::*;
#(
	parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [SLOT_W-1:0]  thread_slot,
	input  logic [LEVEL_W-1:0] level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  picked_slot,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] ready_total,
	output logic [LEVEL_W-1:0] top_level
);

	localparam int LAW = $clog2(PRIO_LEVELS);
	localparam int SAW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ENQ    = 3'd1;
	localparam logic [2:0] S_ENQ2   = 3'd2;
	localparam logic [2:0] S_FETCH  = 3'd3;
	localparam logic [2:0] S_UNLINK = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q;
	logic [1:0] mode_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LAW-1:0] lv_q;
	logic [1:0] status_q;
	logic [SLOT_W-1:0] picked_q;
	logic [COUNT_W-1:0] count_q;
	logic [PRIO_LEVELS-1:0] nonempty_q;
	logic [THREAD_SLOTS-1:0] queued_q;

	logic out_valid_q;
	logic [SLOT_W-1:0] out_picked_q;
	logic [1:0] out_status_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [LEVEL_W-1:0] out_top_q;

	// memories
	logic [SLOT_W-1:0] head_mem [PRIO_LEVELS];
	logic [SLOT_W-1:0] tail_mem [PRIO_LEVELS];
	logic [SLOT_W-1:0] next_mem [THREAD_SLOTS];
	logic [SLOT_W-1:0] prev_mem [THREAD_SLOTS];
	logic [LAW-1:0]    slvl_mem [THREAD_SLOTS];

	logic [SLOT_W-1:0] head_rd, tail_rd, next_rd, prev_rd;
	logic [LAW-1:0] slvl_rd;
	logic [LAW-1:0] head_ra, tail_ra;
	logic [SAW-1:0] link_ra, slvl_ra;

	logic head_we, tail_we, next_we, prev_we, slvl_we;
	logic [LAW-1:0] head_wa, tail_wa;
	logic [SAW-1:0] next_wa, prev_wa, slvl_wa;
	logic [SLOT_W-1:0] head_wd, tail_wd, next_wd, prev_wd;

	logic in_acc;
	logic out_load;
	logic top_found;
	logic [LAW-1:0] top_idx;
	logic lv_bad, slot_bad, in_queued, cur_ne;
	logic [LAW-1:0] fetch_lv;
	logic [SLOT_W-1:0] fetch_slot;
	logic is_head, is_tail;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// encode the most urgent non-empty level
	always_comb begin
		top_found = 1'b0;
		top_idx = '0;
		for (int p = PRIO_LEVELS - 1; p >= 0; p--) begin
			if (nonempty_q[p]) begin
				top_found = 1'b1;
				top_idx = LAW'(p);
			end
		end
	end

	// check request arguments
	always_comb begin
		lv_bad = (32'(level) >= PRIO_LEVELS);
		slot_bad = (32'(thread_slot) >= THREAD_SLOTS);
		in_queued = slot_bad ? 1'b0 : queued_q[SAW'(thread_slot)];
	end

	assign cur_ne = nonempty_q[lv_q];
	assign fetch_lv = (mode_q == MODE_DEQ) ? lv_q : slvl_rd;
	assign fetch_slot = (mode_q == MODE_DEQ) ? head_rd : slot_q;
	assign is_head = (head_rd == slot_q);
	assign is_tail = (tail_rd == slot_q);

	// drive read addresses
	always_comb begin
		head_ra = top_idx;
		tail_ra = (mode == MODE_ENQ) ? LAW'(level) : top_idx;
		link_ra = SAW'(fetch_slot);
		slvl_ra = SAW'(thread_slot);
		if (state_q == S_FETCH) begin
			head_ra = fetch_lv;
			tail_ra = fetch_lv;
		end
	end

	// drive write ports
	always_comb begin
		head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; slvl_we = 1'b0;
		head_wa = lv_q; tail_wa = lv_q;
		next_wa = SAW'(slot_q); prev_wa = SAW'(slot_q); slvl_wa = SAW'(slot_q);
		head_wd = slot_q; tail_wd = slot_q; next_wd = slot_q; prev_wd = slot_q;
		unique case (state_q)
			S_ENQ: begin
				tail_we = 1'b1;
				slvl_we = 1'b1;
				prev_we = 1'b1;
				if (cur_ne) begin
					next_we = 1'b1;
					next_wa = SAW'(tail_rd);
					prev_wd = tail_rd;
				end else begin
					head_we = 1'b1;
				end
			end
			S_ENQ2: begin
				next_we = 1'b1;
			end
			S_UNLINK: begin
				if (is_head && !is_tail) begin
					head_we = 1'b1;
					head_wd = next_rd;
				end else if (is_tail && !is_head) begin
					tail_we = 1'b1;
					tail_wd = prev_rd;
				end else if (!is_head && !is_tail) begin
					next_we = 1'b1;
					next_wa = SAW'(prev_rd);
					next_wd = next_rd;
					prev_we = 1'b1;
					prev_wa = SAW'(next_rd);
					prev_wd = prev_rd;
				end
			end
			default: begin
			end
		endcase
	end

	// read and write the memories
	always_ff @(posedge clk) begin
		head_rd <= head_mem[head_ra];
		tail_rd <= tail_mem[tail_ra];
		next_rd <= next_mem[link_ra];
		prev_rd <= prev_mem[link_ra];
		slvl_rd <= slvl_mem[slvl_ra];
		if (head_we) head_mem[head_wa] <= head_wd;
		if (tail_we) tail_mem[tail_wa] <= tail_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (slvl_we) slvl_mem[slvl_wa] <= lv_q;
	end

	// sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			nonempty_q <= '0;
			queued_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q <= mode;
						slot_q <= thread_slot;
						lv_q <= LAW'(level);
						picked_q <= '0;
						status_q <= ST_OK;
						state_q <= S_OUT;
						case (mode)
							MODE_ENQ: begin
								if (lv_bad || slot_bad || in_queued) status_q <= ST_BAD;
								else state_q <= S_ENQ;
							end
							MODE_DEQ: begin
								lv_q <= top_idx;
								if (!top_found) status_q <= ST_NONE;
								else state_q <= S_FETCH;
							end
							MODE_RMV: begin
								if (slot_bad) status_q <= ST_BAD;
								else if (!in_queued) status_q <= ST_NONE;
								else state_q <= S_FETCH;
							end
							default: status_q <= ST_BAD;
						endcase
					end
				end
				S_ENQ: begin
					nonempty_q[lv_q] <= 1'b1;
					queued_q[SAW'(slot_q)] <= 1'b1;
					count_q <= count_q + 1'b1;
					state_q <= S_ENQ2;
				end
				S_ENQ2: state_q <= S_OUT;
				S_FETCH: begin
					lv_q <= fetch_lv;
					slot_q <= fetch_slot;
					if (mode_q == MODE_DEQ) picked_q <= head_rd;
					state_q <= S_UNLINK;
				end
				S_UNLINK: begin
					if (is_head && is_tail) nonempty_q[lv_q] <= 1'b0;
					queued_q[SAW'(slot_q)] <= 1'b0;
					if (count_q != '0) count_q <= count_q - 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_picked_q <= picked_q;
			out_status_q <= status_q;
			out_count_q <= count_q;
			out_top_q <= top_found ? LEVEL_W'(top_idx) : LEVEL_W'(PRIO_LEVELS);
		end
	end

	assign out_valid = out_valid_q;
	assign picked_slot = out_picked_q;
	assign status = out_status_q;
	assign ready_total = out_count_q;
	assign top_level = out_top_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(queued_q))
		else $error("ready count differs from queued bits");
	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (nonempty_q == '0))
		else $error("non-empty bits disagree with ready count");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted word did not start a request");

endmodule
